>>> rtl/ohd_pkg.sv
// Package: shared types, register indexes and reset constants for the obstacle detector
package ohd_pkg;

	localparam int DIST_W  = 15;
	localparam int COUNT_W = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [DIST_W-1:0]  RESET_DISTANCE_MM    = 15'd10000;
	localparam logic [DIST_W-1:0]  ENTER_THRESHOLD_RST  = 15'd200;
	localparam logic [DIST_W-1:0]  EXIT_THRESHOLD_RST   = 15'd300;
	localparam logic [COUNT_W-1:0] EXIT_SAFE_COUNT_RST  = 16'd25;
	localparam logic [COUNT_W-1:0] INVALID_HOLD_RST     = 16'd250;
	localparam logic [DIST_W-1:0]  MIN_VALID_RST        = 15'd20;
	localparam logic [DIST_W-1:0]  MAX_VALID_RST        = 15'd4500;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENTER_THRESHOLD = 3'd0,
		CFG_EXIT_THRESHOLD  = 3'd1,
		CFG_EXIT_SAFE_COUNT = 3'd2,
		CFG_INVALID_HOLD    = 3'd3,
		CFG_MIN_VALID       = 3'd4,
		CFG_MAX_VALID       = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic       frame_ok;
		logic [7:0] high_byte;
		logic [7:0] low_byte;
	} in_t;

	typedef struct packed {
		logic              obstacle_active;
		logic [DIST_W-1:0] held_distance_mm;
		logic              reading_valid;
	} out_t;

	typedef struct packed {
		logic [DIST_W-1:0]  enter_threshold_mm;
		logic [DIST_W-1:0]  exit_threshold_mm;
		logic [COUNT_W-1:0] exit_safe_count;
		logic [COUNT_W-1:0] invalid_hold_limit;
		logic [DIST_W-1:0]  min_valid_mm;
		logic [DIST_W-1:0]  max_valid_mm;
	} cfg_t;

endpackage

>>> rtl/obstacle_hysteresis_detector.sv
// Top level: distance poll validation, hold/debounce state and obstacle hysteresis flag
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    in_data  (frame_ok, high_byte, low_byte)
//  out      source     out_valid / out_ready  out_data (obstacle_active, held_distance_mm,
//                                                       reading_valid)
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One poll per cycle sustained while the out channel takes results without a stall.
// The input register feeds one pass of compares and counter updates that lands in the
// result register and the state registers together.
// Reset clears the state to a held distance of 10000 mm, empty runs and no obstacle,
// and loads the register defaults; no clearing pass is needed.
// A stalled result holds the input register, which holds the input channel.
module obstacle_hysteresis_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ohd_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ohd_pkg::out_t                    out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ohd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ohd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ohd_pkg::*;

	cfg_t cfg;

	in_t                in_data_s1;
	logic               valid_s1;
	out_t               out_data_q;
	logic               out_valid_q;

	logic [DIST_W-1:0]  held_q;
	logic [COUNT_W-1:0] invalid_run_q;
	logic [COUNT_W-1:0] safe_run_q;
	logic               obstacle_q;

	logic               advance;
	logic               fire;
	logic [15:0]        word;
	logic               reading_valid;
	logic [COUNT_W:0]   invalid_inc;
	logic [DIST_W-1:0]  held_d;
	logic [COUNT_W-1:0] invalid_run_d;
	logic [COUNT_W-1:0] safe_inc;
	logic [COUNT_W-1:0] safe_run_d;
	logic               obstacle_d;

	ohd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: advance stage one whenever the result register is free or drains
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// validate the reading
	assign word = {in_data_s1.high_byte, in_data_s1.low_byte};
	assign reading_valid = in_data_s1.frame_ok && !word[15]
		&& (word[DIST_W-1:0] >= cfg.min_valid_mm)
		&& (word[DIST_W-1:0] <= cfg.max_valid_mm);

	// update held distance and invalid run
	assign invalid_inc = {1'b0, invalid_run_q} + {{COUNT_W{1'b0}}, 1'b1};
	always_comb begin
		held_d        = held_q;
		invalid_run_d = '0;
		if (reading_valid) begin
			held_d = word[DIST_W-1:0];
		end else if (invalid_inc > {1'b0, cfg.invalid_hold_limit}) begin
			held_d = RESET_DISTANCE_MM;
		end else begin
			invalid_run_d = invalid_inc[COUNT_W-1:0];
		end
	end

	// obstacle flag with debounced exit
	assign safe_inc = safe_run_q + {{(COUNT_W-1){1'b0}}, 1'b1};
	always_comb begin
		obstacle_d = obstacle_q;
		safe_run_d = safe_run_q;
		if (!obstacle_q) begin
			if (held_d < cfg.enter_threshold_mm) begin
				obstacle_d = 1'b1;
				safe_run_d = '0;
			end
		end else if (held_d > cfg.exit_threshold_mm) begin
			if (safe_inc >= cfg.exit_safe_count) begin
				obstacle_d = 1'b0;
				safe_run_d = '0;
			end else begin
				safe_run_d = safe_inc;
			end
		end else begin
			safe_run_d = '0;
		end
	end

	// control: stage valid, result valid and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			held_q        <= RESET_DISTANCE_MM;
			invalid_run_q <= '0;
			safe_run_q    <= '0;
			obstacle_q    <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				held_q        <= held_d;
				invalid_run_q <= invalid_run_d;
				safe_run_q    <= safe_run_d;
				obstacle_q    <= obstacle_d;
			end
		end
	end

	// payload: capture request, then result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_s1 <= in_data;
		end
		if (fire) begin
			out_data_q.obstacle_active  <= obstacle_d;
			out_data_q.held_distance_mm <= held_d;
			out_data_q.reading_valid    <= reading_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_safe_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!obstacle_q |-> safe_run_q == '0)
		else $error("safe run nonzero while no obstacle");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.obstacle_active == obstacle_q
			&& out_data_q.held_distance_mm == held_q))
		else $error("pending result differs from detector state");

	a_valid_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.reading_valid |-> invalid_run_q == '0)
		else $error("invalid run not cleared after a valid reading");

	a_fire_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed request produced no result");
`endif

endmodule

>>> rtl/ohd_cfg_regs.sv
// Configuration register file for the obstacle detector
module ohd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ohd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ohd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ohd_pkg::cfg_t                     cfg
);
	import ohd_pkg::*;

	cfg_t cfg_q;

	// accept a write request in every cycle
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_threshold_mm <= ENTER_THRESHOLD_RST;
			cfg_q.exit_threshold_mm  <= EXIT_THRESHOLD_RST;
			cfg_q.exit_safe_count    <= EXIT_SAFE_COUNT_RST;
			cfg_q.invalid_hold_limit <= INVALID_HOLD_RST;
			cfg_q.min_valid_mm       <= MIN_VALID_RST;
			cfg_q.max_valid_mm       <= MAX_VALID_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENTER_THRESHOLD: cfg_q.enter_threshold_mm <= cfg_data[DIST_W-1:0];
				CFG_EXIT_THRESHOLD:  cfg_q.exit_threshold_mm  <= cfg_data[DIST_W-1:0];
				CFG_EXIT_SAFE_COUNT: cfg_q.exit_safe_count    <= cfg_data[COUNT_W-1:0];
				CFG_INVALID_HOLD:    cfg_q.invalid_hold_limit <= cfg_data[COUNT_W-1:0];
				CFG_MIN_VALID:       cfg_q.min_valid_mm       <= cfg_data[DIST_W-1:0];
				CFG_MAX_VALID:       cfg_q.max_valid_mm       <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the obstacle hysteresis detector
`timescale 1ns / 1ps

module tb;
	import ohd_pkg::*;

	localparam int LATENCY     = 2;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	// indexes past the register file, writes there must be dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_t                    in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_t                   out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic idle_on = 1'b1;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   hold_left = 0;
	int   cycle_count = 0;
	int   mismatches = 0;
	int   polls_sent = 0;
	int   reg_writes = 0;
	int   results_checked = 0;

	// detector state as the block should hold it
	cfg_t        model_cfg;
	logic [14:0] held_mm;
	logic [16:0] invalid_run;
	logic [15:0] safe_run;
	logic        obstacle_on;
	out_t        expected_reports[$];

	obstacle_hysteresis_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, expected_reports.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// validate the poll, update hold and debounce state, return the result
	function automatic out_t advance_detector(input in_t p);
		logic [15:0] word;
		logic        good;
		out_t        r;
		word = {p.high_byte, p.low_byte};
		good = p.frame_ok && !word[15] && word[14:0] >= model_cfg.min_valid_mm &&
			word[14:0] <= model_cfg.max_valid_mm;
		if (good) begin
			held_mm = word[14:0];
			invalid_run = '0;
		end else begin
			invalid_run = invalid_run + 17'd1;
			if (invalid_run > {1'b0, model_cfg.invalid_hold_limit}) begin
				held_mm = RESET_DISTANCE_MM;
				invalid_run = '0;
			end
		end
		if (!obstacle_on) begin
			if (held_mm < model_cfg.enter_threshold_mm) begin
				obstacle_on = 1'b1;
				safe_run = '0;
			end
		end else if (held_mm > model_cfg.exit_threshold_mm) begin
			safe_run = safe_run + 16'd1;
			if (safe_run >= model_cfg.exit_safe_count) begin
				obstacle_on = 1'b0;
				safe_run = '0;
			end
		end else begin
			safe_run = '0;
		end
		r.obstacle_active = obstacle_on;
		r.held_distance_mm = held_mm;
		r.reading_valid = good;
		return r;
	endfunction

	// compare one result with the oldest prediction
	task automatic check_report(input out_t got);
		out_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch($sformatf("result with no poll pending (held %0d)",
				got.held_distance_mm));
		end else begin
			want = expected_reports.pop_front();
			results_checked++;
			if (got.obstacle_active !== want.obstacle_active)
				report_mismatch($sformatf("obstacle_active got %0b expected %0b",
					got.obstacle_active, want.obstacle_active));
			if (got.held_distance_mm !== want.held_distance_mm)
				report_mismatch($sformatf("held_distance_mm got %0d expected %0d",
					got.held_distance_mm, want.held_distance_mm));
			if (got.reading_valid !== want.reading_valid)
				report_mismatch($sformatf("reading_valid got %0b expected %0b",
					got.reading_valid, want.reading_valid));
		end
	endtask

	// check results, drive out_ready with random stalls and requested long holds
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_report(out_data);
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			hold_left <= $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic reset_detector();
		model_cfg.enter_threshold_mm = ENTER_THRESHOLD_RST;
		model_cfg.exit_threshold_mm = EXIT_THRESHOLD_RST;
		model_cfg.exit_safe_count = EXIT_SAFE_COUNT_RST;
		model_cfg.invalid_hold_limit = INVALID_HOLD_RST;
		model_cfg.min_valid_mm = MIN_VALID_RST;
		model_cfg.max_valid_mm = MAX_VALID_RST;
		held_mm = RESET_DISTANCE_MM;
		invalid_run = '0;
		safe_run = '0;
		obstacle_on = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	endtask

	// offer one poll, keep valid high afterwards unless a gap follows
	task automatic send_poll(input logic frame, input logic [15:0] word);
		int  gap;
		in_t p;
		p.frame_ok = frame;
		p.high_byte = word[15:8];
		p.low_byte = word[7:0];
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		expected_reports.push_back(advance_detector(p));
		polls_sent++;
	endtask

	// drop valid and wait until every result is back and the pipe is empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_ENTER_THRESHOLD: model_cfg.enter_threshold_mm = data[14:0];
			CFG_EXIT_THRESHOLD:  model_cfg.exit_threshold_mm = data[14:0];
			CFG_EXIT_SAFE_COUNT: model_cfg.exit_safe_count = data;
			CFG_INVALID_HOLD:    model_cfg.invalid_hold_limit = data;
			CFG_MIN_VALID:       model_cfg.min_valid_mm = data[14:0];
			CFG_MAX_VALID:       model_cfg.max_valid_mm = data[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input int enter_dist, input int exit_mm, input int safe_polls,
		input int hold_lim, input int min_mm, input int max_mm);
		write_register(CFG_ENTER_THRESHOLD, 16'(enter_dist));
		write_register(CFG_EXIT_THRESHOLD, 16'(exit_mm));
		write_register(CFG_EXIT_SAFE_COUNT, 16'(safe_polls));
		write_register(CFG_INVALID_HOLD, 16'(hold_lim));
		write_register(CFG_MIN_VALID, 16'(min_mm));
		write_register(CFG_MAX_VALID, 16'(max_mm));
	endtask

	function automatic logic [15:0] near(input int center, input int spread);
		int v;
		v = center - spread + int'($urandom_range(0, 2 * spread));
		if (v < 0)
			v = 0;
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	// distance around the current thresholds and range edges, or anywhere in or outside the valid window
	function automatic logic [15:0] pick_word(input int kind);
		int lo;
		int hi;
		lo = int'(model_cfg.min_valid_mm);
		hi = int'(model_cfg.max_valid_mm);
		case (kind)
			0: return near(int'(model_cfg.enter_threshold_mm), 30);
			1: return near(int'(model_cfg.exit_threshold_mm), 30);
			2: return ($urandom_range(0, 1) != 0) ? near(lo, 3) : near(hi, 3);
			3: return (lo <= hi) ? 16'($urandom_range(lo, hi)) : 16'($urandom_range(0, 32767));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// range edges, negatives and missing frames under reset defaults
	task automatic test_range_checks();
		send_poll(1'b1, 16'd100);
		send_poll(1'b0, 16'd150);
		send_poll(1'b1, 16'h8000);
		send_poll(1'b1, 16'hFFFF);
		send_poll(1'b1, 16'd19);
		send_poll(1'b1, 16'd20);
		send_poll(1'b1, 16'd4500);
		send_poll(1'b1, 16'd4501);
		send_poll(1'b1, 16'h7FFF);
		send_poll(1'b1, 16'd0);
	endtask

	// zero limits, empty valid window, masked and dropped writes
	task automatic test_register_extremes();
		wait_drained();
		write_register(CFG_INVALID_HOLD, 16'd0);
		write_register(CFG_EXIT_SAFE_COUNT, 16'd0);
		send_poll(1'b1, 16'd50);
		send_poll(1'b0, 16'd50);
		send_poll(1'b1, 16'd400);
		wait_drained();
		write_register(CFG_MIN_VALID, 16'h7FFF);
		write_register(CFG_MAX_VALID, 16'd0);
		send_poll(1'b1, 16'd0);
		send_poll(1'b1, 16'h7FFF);
		wait_drained();
		write_register(CFG_ENTER_THRESHOLD, 16'hFFFF);
		write_register(CFG_EXIT_THRESHOLD, 16'hFFFF);
		write_register(CFG_MIN_VALID, 16'h8000);
		write_register(CFG_MAX_VALID, 16'hFFFF);
		write_register(CFG_SPARE_A, 16'd0);
		write_register(CFG_SPARE_B, 16'd0);
		send_poll(1'b1, 16'd0);
		send_poll(1'b1, 16'h7FFE);
		send_poll(1'b1, 16'h7FFF);
	endtask

	// shrink the limits while the runs are part way
	task automatic test_lowered_limits();
		wait_drained();
		apply_setting(200, 300, 4, 5, 20, 4500);
		send_poll(1'b1, 16'd100);
		send_poll(1'b1, 16'd500);
		send_poll(1'b1, 16'd500);
		wait_drained();
		write_register(CFG_EXIT_SAFE_COUNT, 16'd1);
		send_poll(1'b1, 16'd500);
		send_poll(1'b0, 16'd0);
		send_poll(1'b0, 16'd0);
		send_poll(1'b0, 16'd0);
		wait_drained();
		write_register(CFG_INVALID_HOLD, 16'd1);
		send_poll(1'b0, 16'd0);
		wait_drained();
		write_register(CFG_INVALID_HOLD, 16'hFFFF);
		write_register(CFG_EXIT_SAFE_COUNT, 16'hFFFF);
		send_poll(1'b1, 16'd100);
		send_poll(1'b1, 16'd1000);
	endtask

	// runs of related polls across several settings, extremes included
	task automatic test_random_polls();
		int          run_left;
		int          kind;
		int          enter_dist;
		int          exit_mm;
		int          min_mm;
		int          max_mm;
		logic        frame;
		logic [15:0] word;
		run_left = 0;
		kind = 0;
		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			if (ph == 2) begin
				apply_setting(32767, 0, 0, 0, 20, 4500);
			end else if (ph == 4) begin
				apply_setting(0, 32767, 65535, 65535, 0, 32767);
			end else begin
				enter_dist = $urandom_range(0, 800);
				exit_mm = enter_dist + int'($urandom_range(0, 300)) - 50;
				if (exit_mm < 0)
					exit_mm = 0;
				min_mm = $urandom_range(0, 60);
				max_mm = $urandom_range(500, 5000);
				// occasionally close the valid window entirely
				if ($urandom_range(0, 7) == 0) begin
					min_mm = 3000;
					max_mm = $urandom_range(0, 2999);
				end
				apply_setting(enter_dist, exit_mm, $urandom_range(0, 6), $urandom_range(0, 8),
					min_mm, max_mm);
			end
			idle_on <= ($urandom_range(0, 3) != 0);
			for (int i = 0; i < 50; i++) begin
				if (run_left == 0) begin
					kind = $urandom_range(0, 5);
					run_left = $urandom_range(1, 10);
				end
				run_left--;
				if (kind == 5) begin
					// dropout: missing frame, negative or beyond the maximum
					frame = 1'($urandom_range(0, 1));
					if (!frame)
						word = 16'($urandom_range(0, 65535));
					else if ($urandom_range(0, 1) != 0)
						word = {1'b1, 15'($urandom_range(0, 32767))};
					else
						word = near(int'(model_cfg.max_valid_mm) + 40, 30);
				end else begin
					frame = ($urandom_range(0, 15) != 0);
					word = pick_word(kind);
				end
				send_poll(frame, word);
			end
		end
		idle_on <= 1'b1;
	endtask

	// hold the receiver off so the block backs up, then pause the sender
	task automatic test_backpressure();
		wait_drained();
		apply_setting(200, 300, 3, 4, 20, 4500);
		idle_on <= 1'b0;
		holds_asked <= holds_asked + 1;
		for (int i = 0; i < 20; i++)
			send_poll(1'b1, pick_word($urandom_range(0, 4)));
		wait_drained();
		idle_on <= 1'b1;
		for (int i = 0; i < 10; i++)
			send_poll(1'($urandom_range(0, 1)), pick_word($urandom_range(0, 4)));
	endtask

	// back-to-back polls with no stalls on either side
	task automatic test_full_rate();
		idle_on <= 1'b0;
		wait_drained();
		// let any stall burst on the receive side run out
		while (hold_left != 0 || !out_ready) @(posedge clk);
		for (int i = 0; i < 40; i++)
			send_poll(($urandom_range(0, 7) != 0), pick_word($urandom_range(0, 4)));
	endtask

	initial begin
		reset_detector();
		test_range_checks();
		test_register_extremes();
		test_lowered_limits();
		test_random_polls();
		test_backpressure();
		test_full_rate();
		wait_drained();
		$display("Sent %0d polls under %0d register writes; %0d results compared, %0d mismatches.",
			polls_sent, reg_writes, results_checked, mismatches);
		$display("Covered range edges, dropouts, hold resets, hysteresis and back-pressure.");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
